@@ rtl/fcmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcmt_pkg
// Shared constants and types for the fixed-capacity multiset table.
// ----------------------------------------------------------------------------
package fcmt_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;

   // slot index and entry counter widths
   localparam int IDX_WIDTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   // stream widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_FIELD_W = 2 + 2 * CNT_WIDTH;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // operation codes
   localparam logic [REQ_TUSER_W-1:0] OP_ADD      = 3'd0;
   localparam logic [REQ_TUSER_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [REQ_TUSER_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [REQ_TUSER_W-1:0] OP_COUNT    = 3'd3;
   localparam logic [REQ_TUSER_W-1:0] OP_CLEAR    = 3'd4;

   // access control from the sequencer to the entry store
   typedef struct packed {
      logic                   wr_en;
      logic [IDX_WIDTH-1:0]   wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   rd_en;
      logic [IDX_WIDTH-1:0]   rd_addr;
   } store_ctl_type;

endpackage

@@ rtl/fcmt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcmt_store
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcmt_store (
   input  logic                            clock,
   input  fcmt_pkg::store_ctl_type         ctl,
   output logic [fcmt_pkg::VALUE_WIDTH-1:0] rd_data
);

   logic [fcmt_pkg::VALUE_WIDTH-1:0] mem [fcmt_pkg::CAPACITY];
   logic [fcmt_pkg::VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fixed_capacity_multiset_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_capacity_multiset_table
// Unordered multiset of up to CAPACITY values with add, remove, contains,
// count and clear; one response per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     tuser: func, tdata: value
//  rsp_     out        rsp_tvalid/tready     tdata: ok, match_count,
//                                            entry_count, is_empty
//
// Add, clear and unused codes respond without a scan. Remove, contains
// and count scan the store one entry per cycle through a single compare
// unit on the store's read port; a remove that hits then moves the last
// entry into the freed slot. One request is in work at a time; req_tready
// is low from acceptance until the response is taken. Synchronous reset
// empties the table; the store itself is not cleared.
// ----------------------------------------------------------------------------
module fixed_capacity_multiset_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fcmt_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [31:0] value
   input  logic [fcmt_pkg::REQ_TUSER_W-1:0]  req_tuser,  // [2:0] func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] ok, [5:1] match_count, [10:6] entry_count, [11] is_empty, rest zero
   output logic [fcmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_RESP
   } state_type;

   state_type                          state_ff, state_in;
   logic [fcmt_pkg::REQ_TUSER_W-1:0]   func_ff, func_in;
   logic [fcmt_pkg::VALUE_WIDTH-1:0]   value_ff, value_in;
   logic [fcmt_pkg::IDX_WIDTH-1:0]     idx_ff, idx_in;
   logic [fcmt_pkg::CNT_WIDTH-1:0]     fill_ff, fill_in;
   logic                               ok_ff, ok_in;
   logic [fcmt_pkg::CNT_WIDTH-1:0]     match_ff, match_in;

   fcmt_pkg::store_ctl_type            ctl;
   logic [fcmt_pkg::VALUE_WIDTH-1:0]   rd_data;
   logic [fcmt_pkg::CNT_WIDTH-1:0]     fill_dec;
   logic [fcmt_pkg::IDX_WIDTH-1:0]     last_idx;
   logic                               hit;
   logic                               last;

   fcmt_store u_store (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (rd_data)
   );

   assign fill_dec = fill_ff - fcmt_pkg::CNT_WIDTH'(1);
   assign last_idx = fill_dec[fcmt_pkg::IDX_WIDTH-1:0];
   assign hit      = (rd_data == value_ff);
   assign last     = (idx_ff == last_idx);

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      value_in    = value_ff;
      idx_in      = idx_ff;
      fill_in     = fill_ff;
      ok_in       = ok_ff;
      match_in    = match_ff;
      ctl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               value_in = req_tdata[fcmt_pkg::VALUE_WIDTH-1:0];
               ok_in    = 1'b0;
               match_in = '0;
               idx_in   = '0;
               state_in = ST_RESP;
               case (req_tuser)
                  fcmt_pkg::OP_ADD: begin
                     if (fill_ff < fcmt_pkg::CNT_WIDTH'(fcmt_pkg::CAPACITY)) begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = fill_ff[fcmt_pkg::IDX_WIDTH-1:0];
                        ctl.wr_data = req_tdata[fcmt_pkg::VALUE_WIDTH-1:0];
                        fill_in     = fill_ff + fcmt_pkg::CNT_WIDTH'(1);
                        ok_in       = 1'b1;
                     end
                  end
                  fcmt_pkg::OP_CLEAR: begin
                     fill_in = '0;
                  end
                  fcmt_pkg::OP_REMOVE, fcmt_pkg::OP_CONTAINS, fcmt_pkg::OP_COUNT: begin
                     if (fill_ff != '0) begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // compare the entry at idx_ff, prefetch the next one
            idx_in      = idx_ff + fcmt_pkg::IDX_WIDTH'(1);
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = idx_ff + fcmt_pkg::IDX_WIDTH'(1);
            case (func_ff)
               fcmt_pkg::OP_COUNT: begin
                  if (hit) begin
                     match_in = match_ff + fcmt_pkg::CNT_WIDTH'(1);
                  end
                  if (last) begin
                     state_in = ST_RESP;
                  end
               end
               fcmt_pkg::OP_CONTAINS: begin
                  if (hit) begin
                     ok_in    = 1'b1;
                     state_in = ST_RESP;
                  end else if (last) begin
                     state_in = ST_RESP;
                  end
               end
               fcmt_pkg::OP_REMOVE: begin
                  if (hit) begin
                     // hold the slot, fetch the last entry to fill it
                     idx_in      = idx_ff;
                     ctl.rd_addr = last_idx;
                     state_in    = ST_MOVE;
                  end else if (last) begin
                     state_in = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_MOVE: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = idx_ff;
            ctl.wr_data = rd_data;
            fill_in     = fill_dec;
            ok_in       = 1'b1;
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      func_ff  <= func_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      match_ff <= match_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {{fcmt_pkg::RSP_PAD_W{1'b0}}, (fill_ff == '0), fill_ff, match_ff, ok_ff};

endmodule
